>>> rtl/core/atar_pkg.sv
package atar_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_COS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN = 1'b1;
  localparam logic signed [15:0] ROT_COS_RST = 16'sd11585;
  localparam logic signed [15:0] ROT_SIN_RST = 16'sd11585;

  // datapath widths
  localparam int NUM_W = 33;   // rotated x / y, exact, scaled by 2^14
  localparam int MAG_W = 32;   // magnitude of a rotated component
  localparam int SQ_W  = 64;   // sum of squares and root recurrence
  localparam int CX_W  = 36;   // cordic x / y
  localparam int Z_W   = 33;   // cordic angle, units of 2^-30 rad
  localparam int ANG_W = 15;   // Q2.13 output angle
  localparam int RND_W = Z_W - 17;

  // root extraction: one result bit per stage
  localparam int SQ_N     = 32;
  localparam int SQ_IDX_W = $clog2(SQ_N);
  localparam logic [SQ_W-1:0] SQ_TOP_BIT = 64'h4000_0000_0000_0000;

  // cordic stages, bounded by the arctangent table
  localparam int CORDIC_STAGES  = 16;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int ATAN_IDX_W     = $clog2(ATAN_TABLE_LEN);
  localparam int CS_N = (CORDIC_STAGES < ATAN_TABLE_LEN) ? CORDIC_STAGES : ATAN_TABLE_LEN;

  localparam logic [29:0] ATAN_Q30 [ATAN_TABLE_LEN] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
    30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  localparam logic signed [RND_W-1:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [Z_W-1:0]   RND_HALF    = 33'sd65536;

  // special-case marks carried with each angle
  typedef struct packed {
    logic num_zero;
    logic root_zero;
    logic num_neg;
  } special_t;

  // one root extraction lane
  typedef struct packed {
    logic [SQ_W-1:0]         rem;
    logic [SQ_W-1:0]         root;
    logic signed [NUM_W-1:0] num;
  } sqrt_t;

  // one cordic lane
  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    special_t               sp;
  } cordic_t;

  // one step of the digit-by-digit floor square root
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [SQ_IDX_W-1:0] k);
    sqrt_t r;
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] trial;
    r = s;
    bitv = SQ_TOP_BIT >> {k, 1'b0};
    trial = s.root + bitv;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = (s.root >> 1) + bitv;
    end else begin
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // one vectoring micro-rotation
  function automatic cordic_t cordic_step(cordic_t c, logic [ATAN_IDX_W-1:0] k);
    cordic_t r;
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    logic signed [Z_W-1:0]  az;
    r = c;
    xs = c.x >>> k;
    ys = c.y >>> k;
    az = $signed({3'b000, ATAN_Q30[k]});
    if (!c.y[CX_W-1]) begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + az;
    end else begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - az;
    end
    return r;
  endfunction

  // round to Q2.13, saturate, apply the special cases
  function automatic logic signed [ANG_W-1:0] finish_angle(cordic_t c);
    logic signed [Z_W-1:0]   t;
    logic signed [RND_W-1:0] a;
    t = c.z + RND_HALF;
    a = t[Z_W-1:17];
    if (a > HALF_PI_Q13) a = HALF_PI_Q13;
    if (a < -HALF_PI_Q13) a = -HALF_PI_Q13;
    if (c.sp.num_zero) a = '0;
    else if (c.sp.root_zero) a = c.sp.num_neg ? -HALF_PI_Q13 : HALF_PI_Q13;
    return a[ANG_W-1:0];
  endfunction

endpackage

>>> rtl/core/accel_tilt_angles_rotated.sv
// Tilt angles from a rotated three-axis accelerometer sample.
// Input channel: in_valid / in_stall with in_accel_x/y/z (signed 16 bit).
// Result channel: out_valid / out_stall with out_tilt_x, out_tilt_y
// (signed Q2.13 radians) and out_degenerate (bit0 x is 0/0, bit1 y is 0/0).
// Configuration: cfg_we with cfg_index (0 rot_cos, 1 rot_sin) and cfg_data,
// Q1.14 coefficients, to be written by the user only while the pipe is
// empty; the block does not enforce it. The pipe registers products,
// rotate, squares, sum of squares, 32 root-extraction stages (one root
// bit per stage), cordic load, one micro-rotation per stage, and the
// rounding output register. Throughput is one item per cycle unless
// stalled; every stage is a register with a valid.
// When the receiver stalls a valid result, the whole pipe holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads both coefficients with 11585
// (45 degrees).
module accel_tilt_angles_rotated import atar_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          in_accel_x,
  input  logic signed [15:0]          in_accel_y,
  input  logic signed [15:0]          in_accel_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [ANG_W-1:0]     out_tilt_x,
  output logic signed [ANG_W-1:0]     out_tilt_y,
  output logic [1:0]                  out_degenerate,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [15:0]                 cfg_data
);

  logic adv;

  logic signed [15:0] rot_cos_r, rot_sin_r;

  // stage 1: products
  logic               s1_v_r;
  logic signed [31:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic signed [15:0] s1_az_r;

  // stage 2: rotated vector and magnitudes
  logic                    s2_v_r;
  logic signed [NUM_W-1:0] rx_r, ry_r, rx_nxt, ry_nxt;
  logic [MAG_W-1:0]        mx_r, my_r;
  logic [29:0]             mz_r;
  logic [15:0]             az_mag;

  // stage 3: squares
  logic                    s3_v_r;
  logic [SQ_W-1:0]         sx_r, sy_r, sz_r;
  logic signed [NUM_W-1:0] s3_rx_r, s3_ry_r;

  // root extraction and cordic lanes
  logic    sq_v_r [SQ_N+1];
  sqrt_t   sqx_r [SQ_N+1], sqy_r [SQ_N+1], sqx_nxt [SQ_N+1], sqy_nxt [SQ_N+1];
  logic    cd_v_r [CS_N+1];
  cordic_t cdx_r [CS_N+1], cdy_r [CS_N+1], cdx_nxt [CS_N+1], cdy_nxt [CS_N+1];

  logic                    out_v_r;
  logic signed [ANG_W-1:0] tilt_x_r, tilt_y_r;
  logic [1:0]              degen_r;

  // whole pipe moves unless a result is held by the receiver
  assign adv      = !(out_v_r && out_stall);
  assign in_stall = !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_cos_r <= ROT_COS_RST;
      rot_sin_r <= ROT_SIN_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_ROT_COS) rot_cos_r <= $signed(cfg_data);
      else if (cfg_index == REG_ROT_SIN) rot_sin_r <= $signed(cfg_data);
    end
  end

  // rotation sums and magnitudes
  always_comb begin
    rx_nxt = NUM_W'(p_xc_r) + NUM_W'(p_ys_r);
    ry_nxt = NUM_W'(p_yc_r) - NUM_W'(p_xs_r);
    az_mag = s1_az_r[15] ? 16'(-s1_az_r) : 16'(s1_az_r);
  end

  // root lanes and cordic lanes
  always_comb begin
    sqx_nxt[0] = '{rem: sy_r + sz_r, root: '0, num: s3_rx_r};
    sqy_nxt[0] = '{rem: sx_r + sz_r, root: '0, num: s3_ry_r};
    for (int k = 0; k < SQ_N; k++) begin
      sqx_nxt[k+1] = sqrt_step(sqx_r[k], SQ_IDX_W'(k));
      sqy_nxt[k+1] = sqrt_step(sqy_r[k], SQ_IDX_W'(k));
    end
    cdx_nxt[0].x  = $signed({{(CX_W-MAG_W){1'b0}}, sqx_r[SQ_N].root[MAG_W-1:0]});
    cdx_nxt[0].y  = CX_W'(sqx_r[SQ_N].num);
    cdx_nxt[0].z  = '0;
    cdx_nxt[0].sp = '{num_zero: sqx_r[SQ_N].num == '0, root_zero: sqx_r[SQ_N].root == '0,
                      num_neg: sqx_r[SQ_N].num[NUM_W-1]};
    cdy_nxt[0].x  = $signed({{(CX_W-MAG_W){1'b0}}, sqy_r[SQ_N].root[MAG_W-1:0]});
    cdy_nxt[0].y  = CX_W'(sqy_r[SQ_N].num);
    cdy_nxt[0].z  = '0;
    cdy_nxt[0].sp = '{num_zero: sqy_r[SQ_N].num == '0, root_zero: sqy_r[SQ_N].root == '0,
                      num_neg: sqy_r[SQ_N].num[NUM_W-1]};
    for (int k = 0; k < CS_N; k++) begin
      cdx_nxt[k+1] = cordic_step(cdx_r[k], ATAN_IDX_W'(k));
      cdy_nxt[k+1] = cordic_step(cdy_r[k], ATAN_IDX_W'(k));
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k <= SQ_N; k++) sq_v_r[k] <= 1'b0;
      for (int k = 0; k <= CS_N; k++) cd_v_r[k] <= 1'b0;
    end else if (adv) begin
      s1_v_r    <= in_valid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      sq_v_r[0] <= s3_v_r;
      for (int k = 0; k < SQ_N; k++) sq_v_r[k+1] <= sq_v_r[k];
      cd_v_r[0] <= sq_v_r[SQ_N];
      for (int k = 0; k < CS_N; k++) cd_v_r[k+1] <= cd_v_r[k];
      out_v_r   <= cd_v_r[CS_N];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      p_xc_r  <= 32'(in_accel_x) * 32'(rot_cos_r);
      p_ys_r  <= 32'(in_accel_y) * 32'(rot_sin_r);
      p_xs_r  <= 32'(in_accel_x) * 32'(rot_sin_r);
      p_yc_r  <= 32'(in_accel_y) * 32'(rot_cos_r);
      s1_az_r <= in_accel_z;
      rx_r    <= rx_nxt;
      ry_r    <= ry_nxt;
      mx_r    <= rx_nxt[NUM_W-1] ? MAG_W'(-rx_nxt) : MAG_W'(rx_nxt);
      my_r    <= ry_nxt[NUM_W-1] ? MAG_W'(-ry_nxt) : MAG_W'(ry_nxt);
      mz_r    <= {az_mag, 14'b0};
      sx_r    <= SQ_W'(mx_r) * SQ_W'(mx_r);
      sy_r    <= SQ_W'(my_r) * SQ_W'(my_r);
      sz_r    <= SQ_W'(mz_r) * SQ_W'(mz_r);
      s3_rx_r <= rx_r;
      s3_ry_r <= ry_r;
      for (int k = 0; k <= SQ_N; k++) begin
        sqx_r[k] <= sqx_nxt[k];
        sqy_r[k] <= sqy_nxt[k];
      end
      for (int k = 0; k <= CS_N; k++) begin
        cdx_r[k] <= cdx_nxt[k];
        cdy_r[k] <= cdy_nxt[k];
      end
      tilt_x_r <= finish_angle(cdx_r[CS_N]);
      tilt_y_r <= finish_angle(cdy_r[CS_N]);
      degen_r  <= {cdy_r[CS_N].sp.num_zero && cdy_r[CS_N].sp.root_zero,
                   cdx_r[CS_N].sp.num_zero && cdx_r[CS_N].sp.root_zero};
    end
  end

  assign out_valid      = out_v_r;
  assign out_tilt_x     = tilt_x_r;
  assign out_tilt_y     = tilt_y_r;
  assign out_degenerate = degen_r;

endmodule

>>> rtl/core/atar_checker.sv
module atar_checker import atar_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [ANG_W-1:0] out_tilt_x,
  input logic signed [ANG_W-1:0] out_tilt_y,
  input logic [1:0]              out_degenerate
);

  // a held result stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tilt_x) && $stable(out_tilt_y)
      && $stable(out_degenerate))
    else $error("held result changed");

  // input backs up only behind a held result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // an undefined angle reads as zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate[0] |-> out_tilt_x == '0)
    else $error("degenerate x angle not zero");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate[1] |-> out_tilt_y == '0)
    else $error("degenerate y angle not zero");

  // angles stay within half pi
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tilt_x <= 15'sd12868 && out_tilt_x >= -15'sd12868
      && out_tilt_y <= 15'sd12868 && out_tilt_y >= -15'sd12868)
    else $error("angle out of range");

endmodule

bind accel_tilt_angles_rotated atar_checker u_atar_checker (.*);
